/* sv/cfw_pkg.sv */
// ----------------------------------------------------------------------------
// cfw_pkg
// Shared types and constants for the control-flow watchdog.
// ----------------------------------------------------------------------------
package cfw_pkg;

  localparam int unsigned StateW   = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned MaskW    = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // monitored program states
  typedef enum logic [StateW-1:0] {
    ST_START        = 3'd0,
    ST_SORT_PREPARE = 3'd1,
    ST_FIND_MIN     = 3'd2,
    ST_SWAP         = 3'd3,
    ST_NEXT_ROUND   = 3'd4,
    ST_FINISHED     = 3'd5,
    ST_ERROR        = 3'd6,
    ST_UNKNOWN      = 3'd7
  } state_e;

  // watchdog status codes
  typedef enum logic [StatusW-1:0] {
    STS_MONITOR        = 3'd0,
    STS_FINISHED       = 3'd1,
    STS_BAD_TRANSITION = 3'd2,
    STS_TIMEOUT        = 3'd3,
    STS_PROGRAM_ERROR  = 3'd4,
    STS_UNKNOWN        = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ALLOWED_START   = 3'd0,
    REG_ALLOWED_PREPARE = 3'd1,
    REG_ALLOWED_FINDMIN = 3'd2,
    REG_ALLOWED_SWAP    = 3'd3,
    REG_ALLOWED_NEXTIT  = 3'd4,
    REG_TIMEOUT_TICKS   = 3'd5
  } reg_idx_e;

  localparam logic [MaskW-1:0]    AllowedStartRst   = 7'd2;
  localparam logic [MaskW-1:0]    AllowedPrepareRst = 7'd68;
  localparam logic [MaskW-1:0]    AllowedFindMinRst = 7'd72;
  localparam logic [MaskW-1:0]    AllowedSwapRst    = 7'd80;
  localparam logic [MaskW-1:0]    AllowedNextItRst  = 7'd100;
  localparam logic [ElapsedW-1:0] TimeoutTicksRst   = 16'd5;
  localparam logic [ElapsedW-1:0] ElapsedMax        = 16'hFFFF;

  typedef struct packed {
    logic [MaskW-1:0]    allowed_start;
    logic [MaskW-1:0]    allowed_prepare;
    logic [MaskW-1:0]    allowed_find_min;
    logic [MaskW-1:0]    allowed_swap;
    logic [MaskW-1:0]    allowed_next_round;
    logic [ElapsedW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [StateW-1:0] reported_state;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [StateW-1:0]   observed_state;
    logic [ElapsedW-1:0] elapsed;
  } result_t;

endpackage

/* sv/cfw_if.sv */
// ----------------------------------------------------------------------------
// cfw channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface cfw_item_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [cfw_pkg::StateW-1:0] reported_state;

  modport source (output valid, output op, output reported_state, input ready);
  modport sink   (input valid, input op, input reported_state, output ready);
endinterface

interface cfw_result_if;
  logic                         valid;
  logic                         ready;
  logic [cfw_pkg::StatusW-1:0]  status;
  logic [cfw_pkg::StateW-1:0]   observed_state;
  logic [cfw_pkg::ElapsedW-1:0] elapsed;

  modport source (output valid, output status, output observed_state, output elapsed,
                  input ready);
  modport sink   (input valid, input status, input observed_state, input elapsed,
                  output ready);
endinterface

interface cfw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfw_pkg::CfgIdxW-1:0]  index;
  logic [cfw_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/cfw_core.sv */
// ----------------------------------------------------------------------------
// cfw_core
// Watchdog state and the per-item transition / timeout check.
// ----------------------------------------------------------------------------
module cfw_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfw_pkg::item_t   item_i,
  input  cfw_pkg::cfg_t    cfg_i,
  output cfw_pkg::result_t result_o
);

  logic [cfw_pkg::StateW-1:0]   last_state_q, last_state_d;
  logic [cfw_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [cfw_pkg::StatusW-1:0]  halt_status_q, halt_status_d;
  logic                         halted_q, halted_d;

  logic [cfw_pkg::MaskW-1:0]    from_mask;
  logic                         from_checked;
  logic                         target_ok;
  logic [cfw_pkg::ElapsedW-1:0] elapsed_inc;

  // mask of the current state; terminal and unknown states have none
  always_comb begin
    from_mask    = '0;
    from_checked = 1'b1;
    case (cfw_pkg::state_e'(last_state_q))
      cfw_pkg::ST_START:        from_mask = cfg_i.allowed_start;
      cfw_pkg::ST_SORT_PREPARE: from_mask = cfg_i.allowed_prepare;
      cfw_pkg::ST_FIND_MIN:     from_mask = cfg_i.allowed_find_min;
      cfw_pkg::ST_SWAP:         from_mask = cfg_i.allowed_swap;
      cfw_pkg::ST_NEXT_ROUND:   from_mask = cfg_i.allowed_next_round;
      default:                  from_checked = 1'b0;
    endcase
  end

  assign target_ok = from_checked &&
                     (item_i.reported_state != cfw_pkg::StateW'(cfw_pkg::ST_UNKNOWN)) &&
                     from_mask[item_i.reported_state];

  assign elapsed_inc = (elapsed_q == cfw_pkg::ElapsedMax) ? elapsed_q
                                                          : elapsed_q + 16'd1;

  always_comb begin
    last_state_d  = last_state_q;
    elapsed_d     = elapsed_q;
    halt_status_d = halt_status_q;
    halted_d      = halted_q;
    if (!halted_q) begin
      if (item_i.op) begin
        elapsed_d = '0;
        if (item_i.reported_state != last_state_q) begin
          if (target_ok) begin
            last_state_d = item_i.reported_state;
            if (item_i.reported_state == cfw_pkg::StateW'(cfw_pkg::ST_FINISHED)) begin
              halted_d      = 1'b1;
              halt_status_d = cfw_pkg::STS_FINISHED;
            end else if (item_i.reported_state == cfw_pkg::StateW'(cfw_pkg::ST_ERROR)) begin
              halted_d      = 1'b1;
              halt_status_d = cfw_pkg::STS_PROGRAM_ERROR;
            end
          end else begin
            halted_d      = 1'b1;
            halt_status_d = cfw_pkg::STS_BAD_TRANSITION;
          end
        end
      end else begin
        elapsed_d = elapsed_inc;
        // timeout only while in a non-terminal state
        if (from_checked && (elapsed_inc > cfg_i.timeout_ticks)) begin
          halted_d      = 1'b1;
          halt_status_d = cfw_pkg::STS_TIMEOUT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_state_q  <= cfw_pkg::ST_START;
      elapsed_q     <= '0;
      halt_status_q <= cfw_pkg::STS_MONITOR;
      halted_q      <= 1'b0;
    end else if (en_i) begin
      last_state_q  <= last_state_d;
      elapsed_q     <= elapsed_d;
      halt_status_q <= halt_status_d;
      halted_q      <= halted_d;
    end
  end

  // halt status stays at monitoring until a halt, so it serves as the status
  assign result_o.status         = halted_d ? halt_status_d
                                            : cfw_pkg::StatusW'(cfw_pkg::STS_MONITOR);
  assign result_o.observed_state = last_state_d;
  assign result_o.elapsed        = elapsed_d;

endmodule

/* sv/control_flow_watchdog_top.sv */
// ----------------------------------------------------------------------------
// control_flow_watchdog_top
// Control-flow checking watchdog: ticks and state reports in, one status beat
// out per input beat.
// ----------------------------------------------------------------------------
// an input beat passes the input register, then the result register, to reach its result
//   beat; throughput: one beat per cycle while the sink takes results, set by the single
//   compare-and-update pass of the watchdog state
// reset: rst_ni async active low; clears all valids, the watchdog state
//   (START, zero elapsed, monitoring) and loads the default masks and timeout
module control_flow_watchdog_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfw_item_if.sink      in_i,
  cfw_result_if.source  out_o,
  cfw_cfg_if.sink       cfg_i
);

  // configuration registers
  cfw_pkg::cfg_t cfg_q;

  // input stage
  logic           in_vld_q;
  cfw_pkg::item_t item_q;

  // result stage
  logic             out_vld_q;
  cfw_pkg::result_t result_q;
  cfw_pkg::result_t result_d;

  logic advance;
  logic in_take;

  // the input stage moves on when the result register is free or drains now
  assign advance = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready  = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allowed_start      <= cfw_pkg::AllowedStartRst;
      cfg_q.allowed_prepare    <= cfw_pkg::AllowedPrepareRst;
      cfg_q.allowed_find_min   <= cfw_pkg::AllowedFindMinRst;
      cfg_q.allowed_swap       <= cfw_pkg::AllowedSwapRst;
      cfg_q.allowed_next_round <= cfw_pkg::AllowedNextItRst;
      cfg_q.timeout_ticks      <= cfw_pkg::TimeoutTicksRst;
    end else if (cfg_i.valid) begin
      case (cfw_pkg::reg_idx_e'(cfg_i.index))
        cfw_pkg::REG_ALLOWED_START:   cfg_q.allowed_start <= cfg_i.data[cfw_pkg::MaskW-1:0];
        cfw_pkg::REG_ALLOWED_PREPARE: cfg_q.allowed_prepare <= cfg_i.data[cfw_pkg::MaskW-1:0];
        cfw_pkg::REG_ALLOWED_FINDMIN: begin
          cfg_q.allowed_find_min <= cfg_i.data[cfw_pkg::MaskW-1:0];
        end
        cfw_pkg::REG_ALLOWED_SWAP:    cfg_q.allowed_swap <= cfg_i.data[cfw_pkg::MaskW-1:0];
        cfw_pkg::REG_ALLOWED_NEXTIT:  begin
          cfg_q.allowed_next_round <= cfg_i.data[cfw_pkg::MaskW-1:0];
        end
        cfw_pkg::REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register: valid bit under reset, payload free-running on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op             <= in_i.op;
      item_q.reported_state <= in_i.reported_state;
    end
  end

  // watchdog state and check; commits only when the beat moves to the result
  cfw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result_d)
  );

  // result register: holds a beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = result_q.status;
  assign out_o.observed_state = result_q.observed_state;
  assign out_o.elapsed        = result_q.elapsed;

endmodule
